/* sv/ihrp_pkg.sv */
package ihrp_pkg;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 2;
    localparam int ADDR_W = 32;
    localparam int OFS_W  = 16;

    localparam logic [KIND_W-1:0] KIND_DATA     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END_GOOD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END_BAD  = 2'd2;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] ALPHA_BIAS = 8'h37;
    localparam logic [7:0] DIGIT_BIAS = 8'h30;

    localparam logic [7:0] TYPE_DATA    = 8'h00;
    localparam logic [7:0] TYPE_SEGMENT = 8'h02;
    localparam logic [7:0] TYPE_LINEAR  = 8'h04;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        data_byte;
        logic [7:0]        record_type;
    } result_t;

    function automatic logic [3:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [7:0] v;
        v = (c > CHAR_NINE) ? (c - ALPHA_BIAS) : (c - DIGIT_BIAS);
        return v[3:0];
    endfunction

endpackage

/* sv/intel_hex_record_parser.sv */
// Dataflow: a character is captured in the input register, parsed, and any
// result is written to the result register, from which it is transferred.
// Throughput: one character per cycle while the output is not stalled; the parse
// step is a single pass of logic between the input register and the result register.
// Reset: synchronous active-low aresetn clears both stages, the parse phase,
// the checksum and the extended base address.
module intel_hex_record_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] byte_address, [39:32] data_byte, [47:40] record_type
    output logic [1:0]  m_tuser    // [1:0] event_kind
);

    logic                         in_valid_reg;
    logic [ihrp_pkg::CHAR_W-1:0]  in_char_reg;
    logic                         out_valid_reg;
    ihrp_pkg::result_t            out_reg;

    logic                         advance;
    logic                         step_en;
    logic                         res_valid;
    ihrp_pkg::result_t            res;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step_en  = in_valid_reg && advance;

    ihrp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .char_in   (in_char_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (step_en) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= step_en && res_valid;
            end
        end
    end

    // hold the transfer payload while stalled
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.record_type, out_reg.data_byte, out_reg.byte_address};
    assign m_tuser  = out_reg.event_kind;

endmodule

/* sv/ihrp_core.sv */
module ihrp_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step_en,
    input  logic [ihrp_pkg::CHAR_W-1:0]     char_in,
    output logic                            res_valid,
    output ihrp_pkg::result_t               res
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_COUNT  = 3'd1,
        PH_OFS_HI = 3'd2,
        PH_OFS_LO = 3'd3,
        PH_TYPE   = 3'd4,
        PH_DATA   = 3'd5,
        PH_CHECK  = 3'd6
    } phase_t;

    phase_t                           phase_reg, phase_next;
    logic [3:0]                       high_nibble_reg, high_nibble_next;
    logic                             pending_reg, pending_next;
    logic [7:0]                       byte_count_reg, byte_count_next;
    logic [7:0]                       bytes_left_reg, bytes_left_next;
    logic [ihrp_pkg::OFS_W-1:0]       load_offset_reg, load_offset_next;
    logic [7:0]                       type_reg, type_next;
    logic [7:0]                       checksum_reg, checksum_next;
    logic [ihrp_pkg::OFS_W-1:0]       extension_reg, extension_next;
    logic [ihrp_pkg::ADDR_W-1:0]      base_reg, base_next;

    logic [7:0]                  byte_val;
    logic [7:0]                  sum;
    logic [7:0]                  idx;
    logic [ihrp_pkg::OFS_W-1:0]  ofs;

    assign byte_val = {high_nibble_reg, ihrp_pkg::hex_nibble(char_in)};
    assign sum      = checksum_reg + byte_val;
    assign idx      = byte_count_reg - bytes_left_reg;
    assign ofs      = load_offset_reg + {8'd0, idx};

    always_comb begin
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        pending_next     = pending_reg;
        byte_count_next  = byte_count_reg;
        bytes_left_next  = bytes_left_reg;
        load_offset_next = load_offset_reg;
        type_next        = type_reg;
        checksum_next    = checksum_reg;
        extension_next   = extension_reg;
        base_next        = base_reg;
        res_valid        = 1'b0;
        res.event_kind   = ihrp_pkg::KIND_DATA;
        res.byte_address = '0;
        res.data_byte    = '0;
        res.record_type  = type_reg;

        if (step_en) begin
            if (char_in == ihrp_pkg::CHAR_COLON) begin
                phase_next       = PH_COUNT;
                pending_next     = 1'b0;
                high_nibble_next = '0;
                byte_count_next  = '0;
                bytes_left_next  = '0;
                load_offset_next = '0;
                type_next        = '0;
                checksum_next    = '0;
                extension_next   = '0;
            end else if (phase_reg == PH_IDLE) begin
                phase_next = PH_IDLE;
            end else if (!pending_reg) begin
                high_nibble_next = ihrp_pkg::hex_nibble(char_in);
                pending_next     = 1'b1;
            end else begin
                pending_next  = 1'b0;
                checksum_next = sum;
                unique case (phase_reg)
                    PH_COUNT: begin
                        byte_count_next = byte_val;
                        bytes_left_next = byte_val;
                        phase_next      = PH_OFS_HI;
                    end
                    PH_OFS_HI: begin
                        load_offset_next = {byte_val, load_offset_reg[7:0]};
                        phase_next       = PH_OFS_LO;
                    end
                    PH_OFS_LO: begin
                        load_offset_next = {load_offset_reg[15:8], byte_val};
                        phase_next       = PH_TYPE;
                    end
                    PH_TYPE: begin
                        type_next  = byte_val;
                        phase_next = (bytes_left_reg != 8'd0) ? PH_DATA : PH_CHECK;
                    end
                    PH_DATA: begin
                        if (type_reg == ihrp_pkg::TYPE_DATA) begin
                            res_valid        = 1'b1;
                            res.event_kind   = ihrp_pkg::KIND_DATA;
                            res.byte_address = base_reg + {16'd0, ofs};
                            res.data_byte    = byte_val;
                        end else if (type_reg == ihrp_pkg::TYPE_SEGMENT ||
                                     type_reg == ihrp_pkg::TYPE_LINEAR) begin
                            extension_next = {extension_reg[7:0], byte_val};
                        end
                        bytes_left_next = bytes_left_reg - 8'd1;
                        if (bytes_left_reg == 8'd1) begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        res_valid = 1'b1;
                        if (sum == 8'd0) begin
                            res.event_kind = ihrp_pkg::KIND_END_GOOD;
                            if (type_reg == ihrp_pkg::TYPE_SEGMENT) begin
                                base_next = {12'd0, extension_reg, 4'd0};
                            end else if (type_reg == ihrp_pkg::TYPE_LINEAR) begin
                                base_next = {extension_reg, 16'd0};
                            end
                        end else begin
                            res.event_kind = ihrp_pkg::KIND_END_BAD;
                        end
                        phase_next = PH_IDLE;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            high_nibble_reg <= '0;
            pending_reg     <= 1'b0;
            byte_count_reg  <= '0;
            bytes_left_reg  <= '0;
            load_offset_reg <= '0;
            type_reg        <= '0;
            checksum_reg    <= '0;
            extension_reg   <= '0;
            base_reg        <= '0;
        end else begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            pending_reg     <= pending_next;
            byte_count_reg  <= byte_count_next;
            bytes_left_reg  <= bytes_left_next;
            load_offset_reg <= load_offset_next;
            type_reg        <= type_next;
            checksum_reg    <= checksum_next;
            extension_reg   <= extension_next;
            base_reg        <= base_next;
        end
    end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_CHARS = 280;

    localparam logic [7:0] TYPE_EOF       = 8'h01;
    localparam logic [7:0] TYPE_START_SEG = 8'h03;
    localparam logic [7:0] TYPE_START_LIN = 8'h05;

    typedef enum logic [2:0] {
        ST_IDLE, ST_COUNT, ST_OFS_HI, ST_OFS_LO, ST_TYPE, ST_DATA, ST_CHECK
    } parse_state_t;

    typedef struct packed {
        logic [7:0]        ch;
        bit                typed;
        ihrp_pkg::result_t ev;
    } hex_row_t;

    localparam ihrp_pkg::result_t NO_EVENT = '0;

    localparam hex_row_t HEX_ROWS [27] = '{
        '{8'h78, 1'b0, NO_EVENT},
        '{ihrp_pkg::CHAR_COLON, 1'b0, NO_EVENT},
        '{8'h30, 1'b0, NO_EVENT}, '{8'h31, 1'b0, NO_EVENT},
        '{8'h30, 1'b0, NO_EVENT}, '{8'h30, 1'b0, NO_EVENT},
        '{8'h46, 1'b0, NO_EVENT}, '{8'h46, 1'b0, NO_EVENT},
        '{8'h30, 1'b0, NO_EVENT}, '{8'h30, 1'b0, NO_EVENT},
        '{8'h41, 1'b0, NO_EVENT},
        '{8'h42, 1'b1, '{ihrp_pkg::KIND_DATA, 32'h0000_00FF, 8'hAB, ihrp_pkg::TYPE_DATA}},
        '{8'h35, 1'b0, NO_EVENT},
        '{8'h35, 1'b1, '{ihrp_pkg::KIND_END_GOOD, 32'h0, 8'h00, ihrp_pkg::TYPE_DATA}},
        '{8'h0D, 1'b0, NO_EVENT}, '{8'h0A, 1'b0, NO_EVENT},
        '{ihrp_pkg::CHAR_COLON, 1'b0, NO_EVENT},
        '{8'h30, 1'b0, NO_EVENT}, '{8'h30, 1'b0, NO_EVENT},
        '{8'h30, 1'b0, NO_EVENT}, '{8'h30, 1'b0, NO_EVENT},
        '{8'h30, 1'b0, NO_EVENT}, '{8'h30, 1'b0, NO_EVENT},
        '{8'h30, 1'b0, NO_EVENT}, '{8'h31, 1'b0, NO_EVENT},
        '{8'h46, 1'b0, NO_EVENT},
        '{8'h45, 1'b1, '{ihrp_pkg::KIND_END_BAD, 32'h0, 8'h00, TYPE_EOF}}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    intel_hex_record_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    parse_state_t rec_phase = ST_IDLE;
    logic [3:0]   hi_nib = '0;
    logic         half_seen = 1'b0;
    logic [7:0]   rec_len = '0;
    logic [7:0]   remaining = '0;
    logic [15:0]  rec_offset = '0;
    logic [7:0]   rec_type = '0;
    logic [7:0]   sum_acc = '0;
    logic [15:0]  ext_shift = '0;
    logic [31:0]  base_addr = '0;

    ihrp_pkg::result_t pending_events[$];
    int      err_count = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    bit      hold_req = 1'b0;
    int      hold_left = 0;
    int      idle_cycles = 0;
    int      chars_sent = 0;
    int      records_sent = 0;
    int      data_seen = 0;
    int      ends_seen = 0;
    int      bad_seen = 0;

    function automatic bit parse_char(input logic [7:0] c, output ihrp_pkg::result_t ev);
        logic [7:0]  digit;
        logic [7:0]  b;
        logic [7:0]  idx;
        logic [15:0] ofs;
        logic [7:0]  new_sum;
        bit          hit;
        ev = '0;
        hit = 1'b0;
        if (c == ihrp_pkg::CHAR_COLON) begin
            rec_phase = ST_COUNT;
            half_seen = 1'b0;
            hi_nib = '0;
            rec_len = '0;
            remaining = '0;
            rec_offset = '0;
            rec_type = '0;
            sum_acc = '0;
            ext_shift = '0;
            return 1'b0;
        end
        if (rec_phase == ST_IDLE)
            return 1'b0;
        digit = (c > ihrp_pkg::CHAR_NINE) ? c - ihrp_pkg::ALPHA_BIAS : c - ihrp_pkg::DIGIT_BIAS;
        if (!half_seen) begin
            hi_nib = digit[3:0];
            half_seen = 1'b1;
            return 1'b0;
        end
        half_seen = 1'b0;
        b = {hi_nib, digit[3:0]};
        case (rec_phase)
            ST_COUNT: begin
                rec_len = b;
                remaining = b;
                sum_acc = sum_acc + b;
                rec_phase = ST_OFS_HI;
            end
            ST_OFS_HI: begin
                rec_offset[15:8] = b;
                sum_acc = sum_acc + b;
                rec_phase = ST_OFS_LO;
            end
            ST_OFS_LO: begin
                rec_offset[7:0] = b;
                sum_acc = sum_acc + b;
                rec_phase = ST_TYPE;
            end
            ST_TYPE: begin
                rec_type = b;
                sum_acc = sum_acc + b;
                rec_phase = (remaining != 0) ? ST_DATA : ST_CHECK;
            end
            ST_DATA: begin
                idx = rec_len - remaining;
                sum_acc = sum_acc + b;
                if (rec_type == ihrp_pkg::TYPE_DATA) begin
                    ofs = rec_offset + {8'h00, idx};
                    ev.event_kind = ihrp_pkg::KIND_DATA;
                    ev.byte_address = base_addr + {16'h0000, ofs};
                    ev.data_byte = b;
                    ev.record_type = rec_type;
                    hit = 1'b1;
                end else if (rec_type == ihrp_pkg::TYPE_SEGMENT ||
                             rec_type == ihrp_pkg::TYPE_LINEAR) begin
                    ext_shift = {ext_shift[7:0], b};
                end
                remaining = remaining - 8'd1;
                if (remaining == 0)
                    rec_phase = ST_CHECK;
            end
            default: begin
                new_sum = sum_acc + b;
                if (new_sum == 0) begin
                    if (rec_type == ihrp_pkg::TYPE_SEGMENT)
                        base_addr = {12'h000, ext_shift, 4'h0};
                    else if (rec_type == ihrp_pkg::TYPE_LINEAR)
                        base_addr = {ext_shift, 16'h0000};
                end
                sum_acc = new_sum;
                ev.event_kind = (new_sum == 0) ? ihrp_pkg::KIND_END_GOOD
                                               : ihrp_pkg::KIND_END_BAD;
                ev.record_type = rec_type;
                rec_phase = ST_IDLE;
                hit = 1'b1;
            end
        endcase
        return hit;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] g;
        do g = 8'($urandom_range(255)); while (g == ihrp_pkg::CHAR_COLON);
        return g;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return junk_char();
        if (n < 10)
            return 8'h30 + 8'(n);
        return ((r < 30) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    task automatic transfer_char(input logic [7:0] ch, input bit typed = 1'b0,
                                 input ihrp_pkg::result_t typed_ev = '0);
        ihrp_pkg::result_t ev;
        bit      hit;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        do @(posedge aclk); while (!s_tready);
        hit = parse_char(ch, ev);
        if (typed)
            pending_events.push_back(typed_ev);
        else if (hit)
            pending_events.push_back(ev);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_record(input logic [7:0] count, input logic [15:0] offset,
                               input logic [7:0] rtype, input bit bad_sum, input int cut);
        logic [7:0] bytes[$];
        logic [7:0] text[$];
        logic [7:0] sum;
        bytes = '{count, offset[15:8], offset[7:0], rtype};
        for (int i = 0; i < int'(count); i++)
            bytes.push_back(8'($urandom_range(255)));
        sum = '0;
        foreach (bytes[i])
            sum = sum + bytes[i];
        sum = -sum;
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        bytes.push_back(sum);
        text.push_back(ihrp_pkg::CHAR_COLON);
        foreach (bytes[i]) begin
            text.push_back(hex_char(bytes[i][7:4]));
            text.push_back(hex_char(bytes[i][3:0]));
        end
        if (cut > 0 && cut < text.size())
            text = text[0:cut-1];
        foreach (text[i])
            transfer_char(text[i]);
        records_sent++;
    endtask

    task automatic send_random_record();
        int          r;
        logic [7:0]  rtype;
        logic [7:0]  count;
        logic [15:0] offset;
        r = $urandom_range(99);
        if ($urandom_range(99) < 40) begin
            transfer_char(8'h0D);
            transfer_char(8'h0A);
        end
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 4)) transfer_char(junk_char());
        if (r < 55)      rtype = ihrp_pkg::TYPE_DATA;
        else if (r < 65) rtype = ihrp_pkg::TYPE_SEGMENT;
        else if (r < 75) rtype = ihrp_pkg::TYPE_LINEAR;
        else if (r < 82) rtype = TYPE_EOF;
        else if (r < 88) rtype = TYPE_START_SEG;
        else if (r < 92) rtype = TYPE_START_LIN;
        else             rtype = 8'($urandom_range(255));
        if (rtype == ihrp_pkg::TYPE_SEGMENT || rtype == ihrp_pkg::TYPE_LINEAR)
            count = ($urandom_range(99) < 60) ? 8'd2 : 8'($urandom_range(0, 4));
        else
            count = ($urandom_range(99) < 2) ? 8'($urandom_range(17, 255))
                                             : 8'($urandom_range(0, 16));
        offset = ($urandom_range(99) < 20) ? 16'hFFF0 + 16'($urandom_range(15))
                                           : 16'($urandom_range(16'hFFFF));
        send_record(count, offset, rtype, $urandom_range(99) < 12,
                    ($urandom_range(99) < 8) ? $urandom_range(1, 10) : -1);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        ihrp_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected result: event_kind %0d, m_tdata 0x%0h", m_tuser, m_tdata);
                err_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", 32'(want.event_kind), 32'(m_tuser));
                check_field("byte_address", want.byte_address, m_tdata[31:0]);
                check_field("data_byte", 32'(want.data_byte), 32'(m_tdata[39:32]));
                check_field("record_type", 32'(want.record_type), 32'(m_tdata[47:40]));
                if (want.event_kind == ihrp_pkg::KIND_DATA)
                    data_seen++;
                else
                    ends_seen++;
                if (want.event_kind == ihrp_pkg::KIND_END_BAD)
                    bad_seen++;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        int start_chars;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        tx_idle_pct = 34;
        rx_idle_pct = 48;
        foreach (HEX_ROWS[i])
            transfer_char(HEX_ROWS[i].ch, HEX_ROWS[i].typed, HEX_ROWS[i].ev);
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 48 : 0;
            rx_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 34 : 0;
            if (ph == 1)
                hold_req = 1'b1;
            start_chars = chars_sent;
            while (chars_sent - start_chars < PHASE_CHARS)
                send_random_record();
            if (ph == 2)
                send_record(8'hFF, 16'hFF80, ihrp_pkg::TYPE_DATA, 1'b0, -1);
            s_tvalid <= 1'b0;
            do @(negedge aclk); while (pending_events.size() != 0);
        end
        repeat (10) @(posedge aclk);
        $display("summary: %0d characters in %0d records",
                 chars_sent, records_sent);
        $display("summary: %0d data bytes and %0d record ends checked, %0d with bad checksum",
                 data_seen, ends_seen, bad_seen);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
